### rtl/sfd_pkg.sv
// Package for the serial frame deframer.
// Holds the field widths, the result kind codes, the register map and the config struct.
// No dependencies.
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  // result kinds
  localparam logic [KindW-1:0] KindByte    = 2'd0;
  localparam logic [KindW-1:0] KindAccept  = 2'd1;
  localparam logic [KindW-1:0] KindDiscard = 2'd2;

  // request types
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // register map: register i at byte address 4*i
  localparam int unsigned AddrW = 3;
  localparam logic RegTimeout = 1'b0;
  localparam logic RegMaxLen  = 1'b1;

  localparam logic [LenW-1:0] TimeoutReset = 16'd500;
  localparam logic [LenW-1:0] MaxLenReset  = 16'd8192;

  typedef struct packed {
    logic [LenW-1:0] timeout_limit;
    logic [LenW-1:0] max_length;
  } cfg_t;

endpackage

### rtl/sfd_req_if.sv
// Request channel of the deframer: a received byte or an idle tick.
// Depends on sfd_pkg for the field widths.
interface sfd_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [sfd_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

### rtl/sfd_res_if.sv
// Result channel of the deframer: payload bytes and the closing accept/discard.
// Depends on sfd_pkg for the field widths.
interface sfd_res_if;
  logic                       valid;
  logic                       ready;
  logic [sfd_pkg::KindW-1:0]  result_kind;
  logic [sfd_pkg::ByteW-1:0]  payload_byte;
  logic [sfd_pkg::LenW-1:0]   byte_index;
  logic [sfd_pkg::LenW-1:0]   frame_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output byte_index, output frame_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input byte_index, input frame_length, output ready);
endinterface

### rtl/serial_frame_deframer.sv
// Serial frame deframer, top level.
// Depends on sfd_pkg, sfd_req_if, sfd_res_if, sfd_cfg_regs and sfd_parser.
//
// Usage:
//   req_i carries one received byte (req_type 0) or one idle tick (req_type 1)
//   per request. Frames are FF FF, cipher, length lo/hi, payload, sum, FF FE.
//   res_o streams each payload byte with its index as it arrives, then closes
//   the frame with accept (with its length) or discard.
//   An idle count above timeout_limit restarts the parser on the next byte;
//   a frame already partly streamed is then closed with discard.
//   The APB port sets timeout_limit (addr 0) and max_length (addr 4); write
//   only while the block is idle.
// Timing:
//   One request per cycle sustained while res_o does not stall. The request is
//   registered, parsed in one pass against the frame state and the result is
//   registered. Ticks and header bytes produce no result; payload bytes, a bad
//   checksum or trailer and the closing FE produce one each.
// Reset:
//   Parser waits for the first FF, counters clear, registers take 500 / 8192.
// Stall:
//   When res_o stalls with a result held, one more request is taken into the
//   input register; req_i.ready drops after that until the result is taken.
module serial_frame_deframer #(
  parameter logic [sfd_pkg::LenW-1:0] TimeoutInit = sfd_pkg::TimeoutReset,
  parameter logic [sfd_pkg::LenW-1:0] MaxLenInit  = sfd_pkg::MaxLenReset
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfd_req_if.sink                    req_i,
  sfd_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  sfd_pkg::cfg_t cfg;

  sfd_cfg_regs #(
    .TimeoutInit (TimeoutInit),
    .MaxLenInit  (MaxLenInit)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

### rtl/sfd_cfg_regs.sv
// APB-style configuration registers of the deframer (timeout limit, max length).
// Depends on sfd_pkg for the register map and cfg_t.
module sfd_cfg_regs #(
  parameter logic [sfd_pkg::LenW-1:0] TimeoutInit = sfd_pkg::TimeoutReset,
  parameter logic [sfd_pkg::LenW-1:0] MaxLenInit  = sfd_pkg::MaxLenReset
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sfd_pkg::cfg_t              cfg_o
);

  sfd_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        sfd_pkg::RegTimeout: cfg_d.timeout_limit = pwdata[sfd_pkg::LenW-1:0];
        sfd_pkg::RegMaxLen:  cfg_d.max_length    = pwdata[sfd_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit <= TimeoutInit;
      cfg_q.max_length    <= MaxLenInit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfd_pkg::RegTimeout: prdata = {16'd0, cfg_q.timeout_limit};
      sfd_pkg::RegMaxLen:  prdata = {16'd0, cfg_q.max_length};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sfd_parser.sv
// Frame parser: input register, one-pass parse logic and result register.
// Depends on sfd_pkg, sfd_req_if and sfd_res_if.
module sfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfd_pkg::cfg_t  cfg_i,
  sfd_req_if.sink        req_i,
  sfd_res_if.source      res_o
);

  localparam int unsigned PhW = 4;
  localparam logic [PhW-1:0] PhSync1  = 4'd0;
  localparam logic [PhW-1:0] PhSync2  = 4'd1;
  localparam logic [PhW-1:0] PhCipher = 4'd2;
  localparam logic [PhW-1:0] PhLenLo  = 4'd3;
  localparam logic [PhW-1:0] PhLenHi  = 4'd4;
  localparam logic [PhW-1:0] PhBody   = 4'd5;
  localparam logic [PhW-1:0] PhSum    = 4'd6;
  localparam logic [PhW-1:0] PhTail1  = 4'd7;
  localparam logic [PhW-1:0] PhTail2  = 4'd8;

  localparam logic [sfd_pkg::ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [sfd_pkg::ByteW-1:0] EndByte  = 8'hFE;
  localparam logic [sfd_pkg::LenW-1:0]  IdleMax  = '1;

  // input register
  logic                        in_vld_q;
  logic                        in_type_q;
  logic [sfd_pkg::ByteW-1:0]   in_byte_q;

  // parse state
  logic [PhW-1:0]              phase_q, phase_d;
  logic [sfd_pkg::LenW-1:0]    len_q, len_d;
  logic [sfd_pkg::LenW-1:0]    seen_q, seen_d;
  logic [sfd_pkg::ByteW-1:0]   sum_q, sum_d;
  logic [sfd_pkg::LenW-1:0]    idle_q, idle_d;

  // result register
  logic                        out_vld_q;
  logic [sfd_pkg::KindW-1:0]   kind_q, kind_d;
  logic [sfd_pkg::ByteW-1:0]   pbyte_q, pbyte_d;
  logic [sfd_pkg::LenW-1:0]    idx_q, idx_d;
  logic [sfd_pkg::LenW-1:0]    flen_q, flen_d;
  logic                        emit;

  logic                        advance;
  logic                        timed_out;
  logic                        emitted;
  logic [PhW-1:0]              phase_eff;
  logic [sfd_pkg::LenW-1:0]    len_full;
  logic [sfd_pkg::LenW-1:0]    seen_inc;

  assign advance     = in_vld_q & (~out_vld_q | res_o.ready);
  assign req_i.ready = ~in_vld_q | advance;

  assign timed_out = (in_type_q == sfd_pkg::ReqByte) && (idle_q > cfg_i.timeout_limit);
  assign emitted   = (phase_q == PhBody) ? (seen_q != '0)
                   : (phase_q == PhSum || phase_q == PhTail1 || phase_q == PhTail2);
  assign phase_eff = timed_out ? PhSync1 : phase_q;
  assign len_full  = {in_byte_q, len_q[sfd_pkg::ByteW-1:0]};
  assign seen_inc  = seen_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    sum_d   = sum_q;
    idle_d  = idle_q;
    emit    = 1'b0;
    kind_d  = sfd_pkg::KindDiscard;
    pbyte_d = '0;
    idx_d   = '0;
    flen_d  = '0;
    if (in_type_q == sfd_pkg::ReqTick) begin
      if (idle_q != IdleMax) idle_d = idle_q + 1'b1;
    end else begin
      idle_d = '0;
      // timeout mid-frame: downstream drops what it already got
      if (timed_out && emitted) emit = 1'b1;
      unique case (phase_eff)
        PhSync2: begin
          if (in_byte_q == SyncByte) phase_d = PhCipher;
        end
        PhCipher: begin
          phase_d = (in_byte_q == 8'd0 || in_byte_q == 8'd1) ? PhLenLo : PhSync1;
        end
        PhLenLo: begin
          len_d   = {8'd0, in_byte_q};
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d = len_full;
          if (len_full != '0 && len_full <= cfg_i.max_length) begin
            seen_d  = '0;
            sum_d   = '0;
            phase_d = PhBody;
          end else begin
            phase_d = PhSync1;
          end
        end
        PhBody: begin
          sum_d   = sum_q + in_byte_q;
          emit    = 1'b1;
          kind_d  = sfd_pkg::KindByte;
          pbyte_d = in_byte_q;
          idx_d   = seen_q;
          seen_d  = seen_inc;
          if (seen_inc >= len_q) phase_d = PhSum;
        end
        PhSum: begin
          if (sum_q == in_byte_q) begin
            phase_d = PhTail1;
          end else begin
            emit    = 1'b1;
            phase_d = PhSync1;
          end
        end
        PhTail1: begin
          if (in_byte_q == SyncByte) begin
            phase_d = PhTail2;
          end else begin
            emit    = 1'b1;
            phase_d = PhSync1;
          end
        end
        PhTail2: begin
          emit = 1'b1;
          if (in_byte_q == EndByte) begin
            kind_d = sfd_pkg::KindAccept;
            flen_d = len_q;
          end
          phase_d = PhSync1;
        end
        default: begin
          // first sync byte, also the fallback for unused codes
          seen_d  = '0;
          sum_d   = '0;
          phase_d = (in_byte_q == SyncByte) ? PhSync2 : PhSync1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhSync1;
      len_q     <= '0;
      seen_q    <= '0;
      sum_q     <= '0;
      idle_q    <= '0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (advance) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        seen_q  <= seen_d;
        sum_q   <= sum_d;
        idle_q  <= idle_d;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_type_q <= req_i.req_type;
      in_byte_q <= req_i.data_byte;
    end
    if (advance && emit) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      idx_q   <= idx_d;
      flen_q  <= flen_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.result_kind  = kind_q;
  assign res_o.payload_byte = pbyte_q;
  assign res_o.byte_index   = idx_q;
  assign res_o.frame_length = flen_q;

endmodule

### dv/tb_serial_frame_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_deframer: random frames, ticks and stalls.
// Depends on sfd_pkg, sfd_req_if, sfd_res_if and the serial_frame_deframer RTL.
module tb_serial_frame_deframer;
  import sfd_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [ByteW-1:0] TailByte = 8'hFE;
  localparam logic [ByteW-1:0] CipherMax = 8'd1;
  localparam logic [AddrW-1:0] TimeoutAddr = {RegTimeout, 2'b00};
  localparam logic [AddrW-1:0] MaxLenAddr  = {RegMaxLen, 2'b00};

  typedef enum logic [3:0] {
    PhSync1, PhSync2, PhCipher, PhLenLo, PhLenHi, PhBody, PhSum, PhTail1, PhTail2
  } parse_phase_e;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] data_byte;
  } link_req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] pbyte;
    logic [LenW-1:0]  idx;
    logic [LenW-1:0]  flen;
  } frame_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sfd_req_if req_if();
  sfd_res_if res_if();

  serial_frame_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // link traffic waiting to be offered, and the results the parser should produce
  link_req_t   link_q[$];
  frame_res_t  deframed_q[$];

  // mirror of the registers and the parser state
  logic [LenW-1:0] cfg_timeout = TimeoutReset;
  logic [LenW-1:0] cfg_max_len = MaxLenReset;
  parse_phase_e    phase       = PhSync1;
  logic [LenW-1:0] frame_len   = '0;
  logic [LenW-1:0] seen_cnt    = '0;
  logic [ByteW-1:0] sum_acc    = '0;
  logic [LenW-1:0] idle_cnt    = '0;

  int unsigned n_errors;
  int unsigned n_bytes;
  int unsigned cycle_cnt;
  int unsigned req_gap;
  int unsigned res_gap;
  int unsigned hold_left;
  bit          idle_en = 1'b1;
  bit          hold_go;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void expect_res(input logic [KindW-1:0] kind, input logic [ByteW-1:0] b,
                                     input logic [LenW-1:0] idx, input logic [LenW-1:0] len);
    frame_res_t r;
    r.kind  = kind;
    r.pbyte = b;
    r.idx   = idx;
    r.flen  = len;
    deframed_q.push_back(r);
  endfunction

  function automatic void deframe_step(input logic rtype, input logic [ByteW-1:0] d);
    logic [LenW-1:0] len;
    if (rtype == ReqTick) begin
      if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
      return;
    end
    if (idle_cnt > cfg_timeout) begin
      // timed out: a frame already partly streamed gets closed
      if ((phase == PhBody && seen_cnt != '0) || phase == PhSum || phase == PhTail1 ||
          phase == PhTail2)
        expect_res(KindDiscard, '0, '0, '0);
      phase = PhSync1;
    end
    idle_cnt = '0;
    case (phase)
      PhSync2: begin
        if (d == SyncByte) phase = PhCipher;
      end
      PhCipher: begin
        phase = (d <= CipherMax) ? PhLenLo : PhSync1;
      end
      PhLenLo: begin
        frame_len = {8'h00, d};
        phase = PhLenHi;
      end
      PhLenHi: begin
        len = {d, frame_len[7:0]};
        frame_len = len;
        if (len != '0 && len <= cfg_max_len) begin
          seen_cnt = '0;
          sum_acc = '0;
          phase = PhBody;
        end else begin
          phase = PhSync1;
        end
      end
      PhBody: begin
        sum_acc = sum_acc + d;
        expect_res(KindByte, d, seen_cnt, '0);
        seen_cnt = seen_cnt + 1'b1;
        if (seen_cnt >= frame_len) phase = PhSum;
      end
      PhSum: begin
        if (sum_acc == d) begin
          phase = PhTail1;
        end else begin
          expect_res(KindDiscard, '0, '0, '0);
          phase = PhSync1;
        end
      end
      PhTail1: begin
        if (d == SyncByte) begin
          phase = PhTail2;
        end else begin
          expect_res(KindDiscard, '0, '0, '0);
          phase = PhSync1;
        end
      end
      PhTail2: begin
        if (d == TailByte) expect_res(KindAccept, '0, '0, frame_len);
        else expect_res(KindDiscard, '0, '0, '0);
        phase = PhSync1;
      end
      default: begin
        seen_cnt = '0;
        sum_acc = '0;
        phase = (d == SyncByte) ? PhSync2 : PhSync1;
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive_req
    logic nxt_valid;
    logic stalled;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      stalled = req_if.valid && !req_if.ready;
      if (req_if.valid && req_if.ready) begin
        deframe_step(req_if.req_type, req_if.data_byte);
        void'(link_q.pop_front());
      end
      if (stalled) begin
        nxt_valid = 1'b1;
      end else if (req_gap != 0) begin
        req_gap = req_gap - 1;
        nxt_valid = 1'b0;
      end else if (link_q.size() == 0) begin
        nxt_valid = 1'b0;
      end else if (idle_en && hold_left == 0 && $urandom_range(0, 9) == 0) begin
        req_gap = $urandom_range(0, 15);
        nxt_valid = 1'b0;
      end else begin
        nxt_valid = 1'b1;
      end
      req_if.valid <= nxt_valid;
      if (nxt_valid) begin
        req_if.req_type  <= link_q[0].req_type;
        req_if.data_byte <= link_q[0].data_byte;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin : watch_res
    frame_res_t exp_r;
    logic nxt_ready;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (deframed_q.size() == 0) begin
          n_errors++;
          $display({"%0t: unexpected result: expected none,",
                    " got kind %0d byte %02h index %0d length %0d"},
                   $realtime, res_if.result_kind, res_if.payload_byte, res_if.byte_index,
                   res_if.frame_length);
        end else begin
          exp_r = deframed_q.pop_front();
          if (res_if.result_kind !== exp_r.kind || res_if.payload_byte !== exp_r.pbyte ||
              res_if.byte_index !== exp_r.idx || res_if.frame_length !== exp_r.flen) begin
            n_errors++;
            $display({"%0t: result mismatch: expected kind %0d byte %02h index %0d length %0d,",
                      " got kind %0d byte %02h index %0d length %0d"},
                     $realtime, exp_r.kind, exp_r.pbyte, exp_r.idx, exp_r.flen,
                     res_if.result_kind, res_if.payload_byte, res_if.byte_index,
                     res_if.frame_length);
          end
        end
      end
      if (hold_left != 0) begin
        nxt_ready = 1'b0;
      end else if (res_gap != 0) begin
        res_gap = res_gap - 1;
        nxt_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        res_gap = $urandom_range(0, 15);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      res_if.ready <= nxt_ready;
    end
  end

  // one long downstream hold-off so the input side backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic rtype, input logic [ByteW-1:0] b);
    link_req_t it;
    it.req_type  = rtype;
    it.data_byte = b;
    link_q.push_back(it);
    if (rtype == ReqByte) n_bytes++;
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_req(ReqTick, 8'($urandom_range(0, 255)));
  endtask

  // idle gaps on the link, now and then right at the timeout boundary
  task automatic maybe_idle();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (cfg_timeout <= 600 && (cfg_timeout <= 40 ? r < 12 : r < 2))
      push_ticks(cfg_timeout + $urandom_range(0, 1));
    else if (r >= 180)
      push_ticks($urandom_range(1, 3));
  endtask

  task automatic push_frame();
    int unsigned flaw;
    int unsigned len;
    int unsigned cap;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    flaw = $urandom_range(0, 19);
    sum = '0;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_req(ReqByte, 8'($urandom));
    push_req(ReqByte, SyncByte);
    maybe_idle();
    if (flaw == 14) push_req(ReqByte, 8'($urandom_range(0, 254)));
    push_req(ReqByte, SyncByte);
    maybe_idle();
    if (flaw == 15) begin
      push_req(ReqByte, 8'($urandom_range(CipherMax + 1, 255)));
      return;
    end
    push_req(ReqByte, 8'($urandom_range(0, CipherMax)));
    maybe_idle();
    cap = (cfg_max_len < 12) ? cfg_max_len : 12;
    if (flaw == 16)
      len = (cfg_max_len != '1 && $urandom_range(0, 1)) ?
            $urandom_range(cfg_max_len + 1, 65535) : 0;
    else if (cfg_max_len >= 64 && $urandom_range(0, 39) == 0)
      len = $urandom_range(64, (cfg_max_len < 300) ? cfg_max_len : 300);
    else
      len = $urandom_range(1, cap);
    push_req(ReqByte, len[7:0]);
    maybe_idle();
    push_req(ReqByte, len[15:8]);
    if (flaw == 16) return;
    repeat (len) begin
      b = 8'($urandom);
      sum = sum + b;
      push_req(ReqByte, b);
      maybe_idle();
    end
    push_req(ReqByte, (flaw == 17) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    maybe_idle();
    push_req(ReqByte, (flaw == 18) ? 8'($urandom_range(0, 254)) : SyncByte);
    maybe_idle();
    b = 8'($urandom);
    if (b == TailByte) b = SyncByte;
    push_req(ReqByte, (flaw == 19) ? b : TailByte);
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned goal;
    goal = n_bytes + count;
    while (n_bytes < goal) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) push_req(ReqByte, 8'($urandom));
      else push_frame();
    end
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [LenW-1:0] timeout, input logic [LenW-1:0] max_len);
    logic [31:0] rd;
    apb_access(1'b1, TimeoutAddr, {16'h0, timeout}, rd);
    apb_access(1'b1, MaxLenAddr, {16'h0, max_len}, rd);
    cfg_timeout = timeout;
    cfg_max_len = max_len;
    apb_access(1'b0, TimeoutAddr, '0, rd);
    if (rd[LenW-1:0] !== timeout) begin
      n_errors++;
      $display("%0t: timeout_limit readback: expected %0d, got %0d", $realtime, timeout,
               rd[LenW-1:0]);
    end
    apb_access(1'b0, MaxLenAddr, '0, rd);
    if (rd[LenW-1:0] !== max_len) begin
      n_errors++;
      $display("%0t: max_length readback: expected %0d, got %0d", $realtime, max_len,
               rd[LenW-1:0]);
    end
  endtask

  // let every request drain, then give the pipeline time to settle
  task automatic drain();
    while (link_q.size() != 0 || deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = ReqByte;
    req_if.data_byte = '0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'h01); push_req(ReqByte, 8'h00); push_req(ReqByte, 8'h5A);
    push_req(ReqByte, 8'h5A); push_req(ReqByte, SyncByte); push_req(ReqByte, TailByte);
    // stray byte while waiting for second sync, then bad checksum
    push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'h12); push_req(ReqByte, 8'hFF);
    push_req(ReqByte, 8'h01); push_req(ReqByte, 8'h01); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'h00); push_req(ReqByte, 8'h01);
    push_req(ReqTick, 8'hFF);
    // bad cipher, then zero length
    push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'h02);
    push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'hFF); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'h00); push_req(ReqByte, 8'h00);
    drain();

    // every tick times out
    set_config(16'd0, 16'd1);
    push_random(120);
    drain();

    // idle count just above the limit: streamed frame gets dropped
    idle_en <= 1'b0;
    set_config(16'd40, MaxLenReset);
    push_req(ReqByte, SyncByte); push_req(ReqByte, SyncByte); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'h04); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'h11); push_req(ReqByte, 8'h22);
    push_ticks(41);
    push_req(ReqByte, 8'h33);
    push_random(30);
    drain();

    // timeout disabled: frame survives a long silence
    set_config(16'd65535, 16'd3);
    push_req(ReqByte, SyncByte); push_req(ReqByte, SyncByte); push_req(ReqByte, 8'h01);
    push_req(ReqByte, 8'h03); push_req(ReqByte, 8'h00);
    push_req(ReqByte, 8'hAA);
    push_ticks(100);
    push_req(ReqByte, 8'hBB); push_req(ReqByte, 8'hCC); push_req(ReqByte, 8'h31);
    push_req(ReqByte, SyncByte); push_req(ReqByte, TailByte);
    push_random(60);
    drain();
    idle_en <= 1'b1;

    set_config(TimeoutReset, MaxLenReset);
    push_random(60);
    drain();

    set_config(16'($urandom_range(2, 20)), 16'($urandom_range(1, 16)));
    push_random(150);
    drain();

    set_config(16'd65535, 16'd65535);
    push_random(200);
    hold_go <= 1'b1;
    drain();

    // last stretch runs without random valid or ready gaps on the handshakes
    idle_en <= 1'b0;
    set_config(16'($urandom_range(0, 40)), 16'd300);
    push_random(120);
    drain();

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
